@@ design/derivative_filter_peak_search_unit_assert.svh @@
// Assertion macros for the derivative filter peak search unit.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef DERIVATIVE_FILTER_PEAK_SEARCH_UNIT_ASSERT_SVH
`define DERIVATIVE_FILTER_PEAK_SEARCH_UNIT_ASSERT_SVH

// Clocked assertion that is off while reset is asserted.
`define DFPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Assertion of a property in the cycle after a condition holds.
`define DFPS_ASSERT_NEXT(label, cond, prop, msg) \
  `DFPS_ASSERT(label, (cond) |=> (prop), msg)

`endif

@@ design/dfps_pkg.sv @@
// Shared constants and types of the derivative filter peak search unit.
// No dependencies; imported by every module of the block.
package dfps_pkg;

  // Default parameter values.
  localparam int unsigned MAX_SERIES_LEN_DEF = 4096;
  localparam int unsigned SAMPLE_BITS_DEF    = 16;

  // Fixed widths of the register and the result fields.
  localparam int unsigned MOVE_W = 13;
  localparam int unsigned POS_W  = 13;
  localparam int unsigned GRAD_W = 31;

  // Filter weights (gradient scaled by 46080) and half window span.
  localparam int W_NEAR    = 17340;
  localparam int W_MID     = 2832;
  localparam int W_FAR     = 12;
  localparam int WEIGHT_W  = 15;
  localparam int HALF_SPAN = 3;
  localparam int WIN_DEPTH = 6;

  // Reset value of the movement start register: no limit.
  localparam logic signed [MOVE_W-1:0] MOVE_RESET = -13'sd1;

  // Control bits that travel with an item through the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
    logic eval;
  } tag_t;

endpackage

@@ design/derivative_filter_peak_search_unit.sv @@
// Top level of the derivative filter peak search unit.
// Depends on dfps_pkg, dfps_cell, dfps_grad and dfps_peak.
//
// The unit takes one sample per cycle, shifts it through a row of six
// window cells, and evaluates the scaled antisymmetric derivative at the
// window center in a two-stage constant-multiply and add pipeline. A third
// stage keeps the first largest positive gradient. After its last sample is
// accepted, the result of a series passes the gradient and maximum stages
// and sits in an output register until taken. Sustained rate is one sample
// per cycle; the input pauses only when the next series end reaches the
// maximum stage while a result is still held in the output register. The
// pause ends once that result is taken. The movement start register
// is written directly and should change only while idle.
module derivative_filter_peak_search_unit
  import dfps_pkg::*;
#(
  parameter int unsigned MAX_SERIES_LEN = MAX_SERIES_LEN_DEF,
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic signed [MOVE_W-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [POS_W-1:0]              peak_position_o,
  output logic [GRAD_W-1:0]             peak_gradient_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SERIES_LEN + 1);
  localparam int unsigned CMP_W = ((CNT_W > MOVE_W) ? CNT_W : MOVE_W) + 2;
  localparam int unsigned GW    = SAMPLE_BITS + WEIGHT_W + 3;

  logic signed [MOVE_W-1:0]      movement_start_q;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          adv, stall, accept;
  logic                          sat, window_full, skip;
  logic [CNT_W-1:0]              pos, len;
  logic signed [CMP_W-1:0]       pos_ext, move_ext;
  tag_t                          tag_in, tag_mid;
  logic [CNT_W-1:0]              pos_mid, len_mid;
  logic signed [GW-1:0]          grad_mid;
  logic signed [SAMPLE_BITS-1:0] tap [WIN_DEPTH];

  assign adv        = !stall;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Movement start register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      movement_start_q <= MOVE_RESET;
    end else if (cfg_we_i) begin
      movement_start_q <= cfg_wdata_i;
    end
  end

  // Position bookkeeping for the window center of the accepted sample.
  always_comb begin
    sat         = (cnt_q == CNT_W'(MAX_SERIES_LEN));
    window_full = (cnt_q >= CNT_W'(WIN_DEPTH));
    pos         = cnt_q - CNT_W'(HALF_SPAN);
    pos_ext     = $signed(CMP_W'(pos));
    move_ext    = CMP_W'(movement_start_q);
    skip        = (move_ext > CMP_W'(HALF_SPAN)) &&
                  (pos_ext >= move_ext - CMP_W'(HALF_SPAN));
    len         = sat ? cnt_q : cnt_q + CNT_W'(1);
    tag_in.valid = accept;
    tag_in.last  = is_last_i;
    tag_in.eval  = !sat && window_full && !skip;
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = is_last_i ? '0 : len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Row of window cells, newest sample in the first cell.
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_win
    logic signed [SAMPLE_BITS-1:0] cell_d;
    if (k == 0) begin : g_head
      assign cell_d = sample_value_i;
    end else begin : g_link
      assign cell_d = tap[k-1];
    end
    dfps_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(accept && !sat),
      .clear_i(accept && is_last_i),
      .d_i    (cell_d),
      .q_o    (tap[k])
    );
  end

  // Gradient pipeline; the center cell tap[2] is not weighted.
  dfps_grad #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .GW         (GW)
  ) u_grad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .tag_i     (tag_in),
    .pos_i     (pos),
    .len_i     (len),
    .far_new_i (sample_value_i),
    .far_old_i (tap[5]),
    .mid_new_i (tap[0]),
    .mid_old_i (tap[4]),
    .near_new_i(tap[1]),
    .near_old_i(tap[3]),
    .tag_o     (tag_mid),
    .pos_o     (pos_mid),
    .len_o     (len_mid),
    .grad_o    (grad_mid)
  );

  // Running maximum and result register.
  dfps_peak #(
    .CNT_W(CNT_W),
    .GW   (GW)
  ) u_peak (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .tag_i          (tag_mid),
    .pos_i          (pos_mid),
    .len_i          (len_mid),
    .grad_i         (grad_mid),
    .out_ready_i    (out_ready_i),
    .stall_o        (stall),
    .out_valid_o    (out_valid_o),
    .peak_position_o(peak_position_o),
    .peak_gradient_o(peak_gradient_o)
  );

endmodule

@@ design/dfps_cell.sv @@
// One window cell: holds a sample and hands it to its neighbor on a shift.
// Depends on dfps_pkg.
module dfps_cell
  import dfps_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic                          clear_i,
  input  logic signed [SAMPLE_BITS-1:0] d_i,
  output logic signed [SAMPLE_BITS-1:0] q_o
);

  logic signed [SAMPLE_BITS-1:0] sample_q;

  // A series end empties the cell; otherwise a shift loads the neighbor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (clear_i) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

@@ design/dfps_grad.sv @@
// Two-stage gradient pipeline: weighted differences, then their sum.
// Depends on dfps_pkg.
module dfps_grad
  import dfps_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned CNT_W       = 13,
  parameter int unsigned GW          = SAMPLE_BITS + WEIGHT_W + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  tag_t                          tag_i,
  input  logic [CNT_W-1:0]              pos_i,
  input  logic [CNT_W-1:0]              len_i,
  input  logic signed [SAMPLE_BITS-1:0] far_new_i,
  input  logic signed [SAMPLE_BITS-1:0] far_old_i,
  input  logic signed [SAMPLE_BITS-1:0] mid_new_i,
  input  logic signed [SAMPLE_BITS-1:0] mid_old_i,
  input  logic signed [SAMPLE_BITS-1:0] near_new_i,
  input  logic signed [SAMPLE_BITS-1:0] near_old_i,
  output tag_t                          tag_o,
  output logic [CNT_W-1:0]              pos_o,
  output logic [CNT_W-1:0]              len_o,
  output logic signed [GW-1:0]          grad_o
);

  localparam int unsigned DW = SAMPLE_BITS + 1;
  localparam int unsigned PW = DW + WEIGHT_W;

  localparam logic signed [PW-1:0] K_FAR  = PW'(W_FAR);
  localparam logic signed [PW-1:0] K_MID  = PW'(W_MID);
  localparam logic signed [PW-1:0] K_NEAR = PW'(W_NEAR);

  logic signed [DW-1:0] diff_far, diff_mid, diff_near;
  logic signed [PW-1:0] prod_far_d, prod_mid_d, prod_near_d;
  logic signed [PW-1:0] prod_far_q, prod_mid_q, prod_near_q;
  logic signed [GW-1:0] grad_d, grad_q;
  tag_t                 tag1_q, tag2_q;
  logic [CNT_W-1:0]     pos1_q, pos2_q, len1_q, len2_q;

  // Stage one: differences across the window center and constant products.
  always_comb begin
    diff_far    = DW'(far_new_i) - DW'(far_old_i);
    diff_mid    = DW'(mid_new_i) - DW'(mid_old_i);
    diff_near   = DW'(near_new_i) - DW'(near_old_i);
    prod_far_d  = PW'(diff_far) * K_FAR;
    prod_mid_d  = PW'(diff_mid) * K_MID;
    prod_near_d = PW'(diff_near) * K_NEAR;
  end

  // Stage two: the scaled gradient is the sum of the three products.
  assign grad_d = GW'(prod_far_q) + GW'(prod_mid_q) + GW'(prod_near_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (adv_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_far_q  <= prod_far_d;
      prod_mid_q  <= prod_mid_d;
      prod_near_q <= prod_near_d;
      pos1_q      <= pos_i;
      len1_q      <= len_i;
      grad_q      <= grad_d;
      pos2_q      <= pos1_q;
      len2_q      <= len1_q;
    end
  end

  assign tag_o  = tag2_q;
  assign pos_o  = pos2_q;
  assign len_o  = len2_q;
  assign grad_o = grad_q;

endmodule

@@ design/dfps_peak.sv @@
// Running maximum of the gradient and the result register.
// Depends on dfps_pkg.
module dfps_peak
  import dfps_pkg::*;
#(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned GW    = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  tag_t                 tag_i,
  input  logic [CNT_W-1:0]     pos_i,
  input  logic [CNT_W-1:0]     len_i,
  input  logic signed [GW-1:0] grad_i,
  input  logic                 out_ready_i,
  output logic                 stall_o,
  output logic                 out_valid_o,
  output logic [POS_W-1:0]     peak_position_o,
  output logic [GRAD_W-1:0]    peak_gradient_o
);

  logic signed [GW-1:0] best_q, best_next;
  logic [CNT_W-1:0]     best_pos_q, pos_next;
  logic                 found_q, found_next;
  logic                 better, take;
  logic                 out_valid_q;
  logic [POS_W-1:0]     position_q;
  logic [GRAD_W-1:0]    gradient_q;

  // Strictly greater keeps the first position of a tie.
  always_comb begin
    better     = tag_i.eval && (grad_i > best_q);
    best_next  = better ? grad_i : best_q;
    pos_next   = better ? pos_i : best_pos_q;
    found_next = found_q || better;
    take       = adv_i && tag_i.valid;
  end

  // Hold the pipeline while a result waits and the next one is ready.
  assign stall_o = out_valid_q && tag_i.valid && tag_i.last;

  // Maximum tracking; the last item of a series starts a fresh search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      best_pos_q  <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (tag_i.last) begin
          best_q     <= '0;
          best_pos_q <= '0;
          found_q    <= 1'b0;
        end else begin
          best_q     <= best_next;
          best_pos_q <= pos_next;
          found_q    <= found_next;
        end
      end
      if (take && tag_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: the peak, or the series length when nothing was positive.
  always_ff @(posedge clk_i) begin
    if (take && tag_i.last) begin
      if (found_next) begin
        position_q <= POS_W'(pos_next);
        gradient_q <= GRAD_W'($unsigned(best_next));
      end else begin
        position_q <= POS_W'(len_i);
        gradient_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign peak_position_o = position_q;
  assign peak_gradient_o = gradient_q;

endmodule

@@ design/dfps_checker.sv @@
// Port checker for the derivative filter peak search unit and its bind.
// Depends on dfps_pkg and derivative_filter_peak_search_unit_assert.svh.
`include "derivative_filter_peak_search_unit_assert.svh"

module dfps_checker
  import dfps_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [POS_W-1:0]              peak_position_o,
  input logic [GRAD_W-1:0]             peak_gradient_o
);

  // A result item stays offered until it is taken.
  `DFPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result item dropped")

  // A stalled result item keeps its payload.
  `DFPS_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
    $stable(peak_position_o) && $stable(peak_gradient_o), "result payload changed")

  // The input only pauses behind a waiting result item.
  `DFPS_ASSERT(a_stall_cause, !in_ready_o |-> out_valid_o, "input paused without result")

  // Taking the result item always frees the input.
  `DFPS_ASSERT_NEXT(a_stall_clears, out_valid_o && out_ready_i, in_ready_o, "input still paused")

endmodule

bind derivative_filter_peak_search_unit dfps_checker u_dfps_checker (.*);

@@ tb/derivative_filter_peak_search_unit_test.sv @@
// Self-checking testbench for derivative_filter_peak_search_unit.
// Depends on dfps_pkg and the unit; a gradient tracker of its own predicts every untyped peak result.
// Runs a directed table, then random series under several movement limits and stall patterns.
module derivative_filter_peak_search_unit_test;
  import dfps_pkg::*;

  // Filter taps and series limits, kept apart from the design's own copy.
  localparam int TAP_NEAR       = 17340;
  localparam int TAP_MID        = 2832;
  localparam int TAP_FAR        = 12;
  localparam int SPAN           = 3;
  localparam int SERIES_CAP     = 4096;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int PHASES         = 9;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 1000;
  localparam int DIRECTED_ROWS  = 23;

  localparam logic signed [15:0] S_MIN     = 16'sh8000;
  localparam logic signed [15:0] S_MAX     = 16'sh7FFF;
  localparam logic [GRAD_W-1:0]  GRAD_PEAK = 31'd1322758440;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [GRAD_W-1:0] grad;
  } peak_t;

  // One row of the directed table; typed rows carry their result by hand.
  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
    logic               typed;
    logic [POS_W-1:0]   pos;
    logic [GRAD_W-1:0]  grad;
  } stim_row_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic signed [MOVE_W-1:0] cfg_wdata_i    = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic signed [15:0]       sample_value_i = '0;
  logic                     is_last_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [POS_W-1:0]         peak_position_o;
  logic [GRAD_W-1:0]        peak_gradient_o;

  int    send_idle_pct  = 24;
  int    recv_idle_pct  = 52;
  int    mismatch_count = 0;
  int    quiet_cycles   = 0;
  peak_t expected_peaks_q[$];

  // Gradient tracker state, cleared at the end of every series.
  int     trk_window[6]   = '{default: 0};
  int     trk_count       = 0;
  longint trk_best        = 0;
  int     trk_best_pos    = 0;
  bit     trk_found       = 1'b0;
  int     trk_move_start  = -1;

  // Directed items: a lone sample, the steepest rise, the steepest fall, a mixed series.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'sd0,    1'b1, 1'b1, 13'd1, 31'd0},
    '{S_MIN,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MIN,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MIN,     1'b0, 1'b0, 13'd0, 31'd0},
    '{16'sd0,    1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MAX,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MAX,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MAX,     1'b1, 1'b1, 13'd3, GRAD_PEAK},
    '{S_MAX,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MAX,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MAX,     1'b0, 1'b0, 13'd0, 31'd0},
    '{16'sd0,    1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MIN,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MIN,     1'b0, 1'b0, 13'd0, 31'd0},
    '{S_MIN,     1'b1, 1'b1, 13'd7, 31'd0},
    '{16'sd5,    1'b0, 1'b0, 13'd0, 31'd0},
    '{-16'sd3,   1'b0, 1'b0, 13'd0, 31'd0},
    '{16'sd100,  1'b0, 1'b0, 13'd0, 31'd0},
    '{16'sd7,    1'b0, 1'b0, 13'd0, 31'd0},
    '{-16'sd200, 1'b0, 1'b0, 13'd0, 31'd0},
    '{16'sd40,   1'b0, 1'b0, 13'd0, 31'd0},
    '{16'sd1000, 1'b0, 1'b0, 13'd0, 31'd0},
    '{-16'sd1,   1'b1, 1'b0, 13'd0, 31'd0}
  };

  int move_settings [7] = '{-1, 4095, 0, 3, 4, 7, 10};

  derivative_filter_peak_search_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_value_i  (sample_value_i),
    .is_last_i       (is_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .peak_position_o (peak_position_o),
    .peak_gradient_o (peak_gradient_o)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stalls at random in the current share of cycles.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Counts a mismatch and prints one line about it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, wanted %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Tracks the first largest positive gradient of the series and gives the peak on its last item.
  task automatic track_sample(input logic signed [15:0] value, input logic last,
                              output bit emits, output peak_t peak);
    int     cur;
    int     pos;
    longint grad;
    cur   = value;
    emits = 1'b0;
    peak  = '0;
    if (trk_count < SERIES_CAP) begin
      if (trk_count >= 2 * SPAN) begin
        pos = trk_count - SPAN;
        // When the movement start exceeds the span, positions at or past it minus the span are skipped.
        if (!(trk_move_start > SPAN && pos >= trk_move_start - SPAN)) begin
          grad = longint'(TAP_FAR) * (cur - trk_window[5])
               + longint'(TAP_MID) * (trk_window[0] - trk_window[4])
               + longint'(TAP_NEAR) * (trk_window[1] - trk_window[3]);
          if (grad > trk_best) begin
            trk_best     = grad;
            trk_best_pos = pos;
            trk_found    = 1'b1;
          end
        end
      end
      for (int k = 5; k > 0; k--) trk_window[k] = trk_window[k-1];
      trk_window[0] = cur;
      trk_count++;
    end
    // A series end reports the peak, or the length when nothing rose.
    if (last) begin
      emits     = 1'b1;
      peak.pos  = trk_found ? POS_W'(trk_best_pos) : POS_W'(trk_count);
      peak.grad = trk_found ? GRAD_W'(trk_best) : '0;
      trk_window   = '{default: 0};
      trk_count    = 0;
      trk_best     = 0;
      trk_best_pos = 0;
      trk_found    = 1'b0;
    end
  endtask

  // Offers one item after a random gap and waits until it is accepted.
  task automatic push_sample(input logic signed [15:0] value, input logic last,
                             input bit typed, input peak_t typed_peak);
    bit    emits;
    peak_t peak;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    is_last_i      <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_sample(value, last, emits, peak);
    if (emits) expected_peaks_q.push_back(typed ? typed_peak : peak);
  endtask

  // Holds the input off until every pending result is out, then lets the pipeline settle.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_peaks_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes the movement start register; called at a falling edge while idle.
  task automatic write_move_start(input int setting);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= MOVE_W'(setting);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    trk_move_start = setting;
  endtask

  // Result checking against the oldest pending peak, plus the stall watchdog.
  always @(posedge clk_i) begin : result_check
    peak_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_peaks_q.size() == 0) begin
          report_mismatch("unexpected result position", peak_position_o, -1);
        end else begin
          want = expected_peaks_q.pop_front();
          if (peak_position_o !== want.pos)
            report_mismatch("peak_position", peak_position_o, want.pos);
          if (peak_gradient_o !== want.grad)
            report_mismatch("peak_gradient", peak_gradient_o, want.grad);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    peak_t              typed_peak;
    logic signed [15:0] value;
    int                 phase_items;
    int                 len;
    int                 style;
    int                 level;
    int                 setting;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table under the reset movement limit.
    foreach (directed_rows[r]) begin
      typed_peak.pos  = directed_rows[r].pos;
      typed_peak.grad = directed_rows[r].grad;
      push_sample(directed_rows[r].value, directed_rows[r].last, directed_rows[r].typed,
                  typed_peak);
    end

    // Random series, one movement setting per phase, stall pattern by thirds.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p < PHASES / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 52;
      end else if (p < 2 * PHASES / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p < 7) setting = move_settings[p];
      else if (p == 7) setting = $urandom_range(64, 4);
      else setting = $urandom_range(4095, 0);
      write_move_start(setting);

      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / PHASES) begin
        // Mostly medium series, some short ones mostly too short to evaluate, a few long ones.
        style = $urandom_range(99);
        if (style < 10) len = $urandom_range(7, 1);
        else if (style < 80) len = $urandom_range(30, 8);
        else len = $urandom_range(120, 31);
        style = $urandom_range(3);
        level = int'($urandom_range(65535)) - 32768;
        for (int k = 0; k < len; k++) begin
          case (style)
            0: value = 16'($urandom);
            // Small values give flat stretches and tied gradients.
            1: value = 16'(int'($urandom_range(4)) - 2);
            // A drifting level gives long positive slopes.
            2: begin
              level = level + int'($urandom_range(600)) - 200;
              value = 16'(level);
            end
            default: value = $urandom_range(1) ? S_MAX : S_MIN;
          endcase
          push_sample(value, k == len - 1, 1'b0, '0);
        end
        phase_items += len;
      end
    end
    drain_results();

    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
